// ===== hdl/iorq_pkg.sv =====
// ----------------------------------------------------------------------------
// iorq_pkg
// Shared command, status and cell-control codes for the indexed ordered queue.
// ----------------------------------------------------------------------------
package iorq_pkg;

    typedef enum logic [2:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_READ   = 3'd2,
        OP_INSERT = 3'd3,
        OP_REMOVE = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // per-cell action for the current cycle
    typedef enum logic [1:0] {
        CM_HOLD = 2'd0,
        CM_LOAD = 2'd1,
        CM_UP   = 2'd2,
        CM_DOWN = 2'd3
    } t_cell_mode;

endpackage

// ===== hdl/iorq_cell.sv =====
// ----------------------------------------------------------------------------
// iorq_cell
// One storage slot of the queue. Holds, loads the incoming word, or takes
// the word of the neighbour below (gap opening) or above (gap closing).
// ----------------------------------------------------------------------------
module iorq_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  iorq_pkg::t_cell_mode  i_mode,
    input  logic [DATA_WIDTH-1:0] i_load,
    input  logic [DATA_WIDTH-1:0] i_lower,
    input  logic [DATA_WIDTH-1:0] i_upper,
    output logic [DATA_WIDTH-1:0] o_q
);

    logic [DATA_WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        case (i_mode)
            iorq_pkg::CM_LOAD: r_q <= i_load;
            iorq_pkg::CM_UP:   r_q <= i_lower;
            iorq_pkg::CM_DOWN: r_q <= i_upper;
            default:           r_q <= r_q;
        endcase
    end

    assign o_q = r_q;

endmodule

// ===== hdl/indexed_ordered_queue.sv =====
// ----------------------------------------------------------------------------
// indexed_ordered_queue
// Ordered queue of up to DEPTH words with push, pop, indexed read,
// insert-after and remove, held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Command channel: i_valid / o_ready carry opcode, position and data_in.
// Result channel: o_valid / i_ready carry data_out, count and status; every
// command gives exactly one result word.
// Result: registered, valid in the cycle after the command is taken.
// Throughput: one command per cycle while results are taken. Shifting cells
// update together, each copying from its neighbour, so an insert or remove
// anywhere does not stall; the indexed read is a single mux over the cells.
// Stall: the result register holds while i_ready is low, and o_ready drops
// until it is taken, so no command is lost or run ahead.
// Reset: the count and result valid clear; stored words are undefined until
// written and are never read before that.
// A failed command (empty, out of range, full) leaves the queue unchanged.
// ----------------------------------------------------------------------------
module indexed_ordered_queue #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [2:0]                    i_opcode,
    input  logic [3:0]                    i_position,
    input  logic [DATA_WIDTH-1:0]         i_data_in,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [DATA_WIDTH-1:0]         o_data_out,
    output logic [$clog2(DEPTH+1)-1:0]    o_count,
    output logic [1:0]                    o_status
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CMP_W = ((CNT_W > 4) ? CNT_W : 4) + 1;

    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic                   r_out_valid;
    logic [DATA_WIDTH-1:0]  r_data_out;
    logic [DATA_WIDTH-1:0]  n_data_out;
    iorq_pkg::t_status      r_status;
    iorq_pkg::t_status      n_status;

    logic                   accept;
    logic                   full;
    logic                   empty;
    logic                   in_range;
    logic [CMP_W-1:0]       pos_x;
    logic [CMP_W-1:0]       cnt_x;
    logic [CMP_W-1:0]       ins_at;
    logic [CMP_W-1:0]       rem_from;
    logic                   do_push;
    logic                   do_insert;
    logic                   do_remove;

    logic [DATA_WIDTH-1:0]  w_q    [DEPTH];
    iorq_pkg::t_cell_mode   w_mode [DEPTH];

    assign o_ready  = !r_out_valid || i_ready;
    assign accept   = i_valid && o_ready;
    assign full     = (r_count == CNT_W'(DEPTH));
    assign empty    = (r_count == '0);
    assign pos_x    = CMP_W'(i_position);
    assign cnt_x    = CMP_W'(r_count);
    assign in_range = (pos_x < cnt_x);
    assign ins_at   = pos_x + CMP_W'(1);

    always_comb begin
        n_data_out = '0;
        n_status   = iorq_pkg::ST_OK;
        n_count    = r_count;
        do_push    = 1'b0;
        do_insert  = 1'b0;
        do_remove  = 1'b0;
        rem_from   = pos_x;
        case (iorq_pkg::t_opcode'(i_opcode))
            iorq_pkg::OP_PUSH: begin
                if (full) begin
                    n_status = iorq_pkg::ST_FULL;
                end else begin
                    do_push = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
            iorq_pkg::OP_POP: begin
                if (empty) begin
                    n_status = iorq_pkg::ST_EMPTY;
                end else begin
                    n_data_out = w_q[0];
                    do_remove  = 1'b1;
                    rem_from   = '0;
                    n_count    = r_count - CNT_W'(1);
                end
            end
            iorq_pkg::OP_READ: begin
                if (empty) begin
                    n_status = iorq_pkg::ST_EMPTY;
                end else if (!in_range) begin
                    n_status = iorq_pkg::ST_RANGE;
                end else begin
                    n_data_out = w_q[pos_x[IDX_W-1:0]];
                end
            end
            iorq_pkg::OP_INSERT: begin
                if (!in_range) begin
                    n_status = iorq_pkg::ST_RANGE;
                end else if (full) begin
                    n_status = iorq_pkg::ST_FULL;
                end else begin
                    do_insert = 1'b1;
                    n_count   = r_count + CNT_W'(1);
                end
            end
            iorq_pkg::OP_REMOVE: begin
                if (!in_range) begin
                    n_status = iorq_pkg::ST_RANGE;
                end else begin
                    do_remove = 1'b1;
                    n_count   = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_status = iorq_pkg::ST_OK;
            end
        endcase
    end

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        localparam logic [CMP_W-1:0] IX = CMP_W'(gi);
        logic [DATA_WIDTH-1:0] lower;
        logic [DATA_WIDTH-1:0] upper;

        always_comb begin
            if (!accept) begin
                w_mode[gi] = iorq_pkg::CM_HOLD;
            end else if (do_push && IX == cnt_x) begin
                w_mode[gi] = iorq_pkg::CM_LOAD;
            end else if (do_insert && IX == ins_at) begin
                w_mode[gi] = iorq_pkg::CM_LOAD;
            end else if (do_insert && IX > ins_at) begin
                w_mode[gi] = iorq_pkg::CM_UP;
            end else if (do_remove && IX >= rem_from) begin
                w_mode[gi] = iorq_pkg::CM_DOWN;
            end else begin
                w_mode[gi] = iorq_pkg::CM_HOLD;
            end
        end

        if (gi == 0) begin : g_first
            assign lower = i_data_in;
        end else begin : g_mid_lo
            assign lower = w_q[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_last
            assign upper = w_q[gi];
        end else begin : g_mid_hi
            assign upper = w_q[gi+1];
        end

        iorq_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_mode  (w_mode[gi]),
            .i_load  (i_data_in),
            .i_lower (lower),
            .i_upper (upper),
            .o_q     (w_q[gi])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data_out <= n_data_out;
            r_status   <= n_status;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_data_out = r_data_out;
    assign o_count    = r_count;
    assign o_status   = r_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("count above depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_opcode == iorq_pkg::OP_PUSH && !full)
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("push did not grow count");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == iorq_pkg::ST_FULL) |-> (o_count == CNT_W'(DEPTH)))
        else $error("full status with room left");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == iorq_pkg::ST_EMPTY) |-> (o_count == '0))
        else $error("empty status with entries held");

endmodule
